/* rtl/dce_pkg.sv */
// Shared constants, command codes and helper functions of the dimmer command engine.
// Depends on nothing; used by the core.
`default_nettype none
package dce_pkg;

  localparam logic [7:0] CMD_GRP_EDIT  = 8'd9;
  localparam logic [7:0] CMD_SET_SHORT = 8'd34;
  localparam logic [7:0] CMD_LOAD_DTR  = 8'd35;
  localparam logic [7:0] CMD_STORE_DTR = 8'd36;
  localparam logic [7:0] CMD_QRY_DTR   = 8'd37;
  localparam logic [7:0] CMD_READ_NV   = 8'd38;
  localparam logic [7:0] CMD_QRY_LEVEL = 8'd39;
  localparam logic [7:0] CMD_SET_MAX   = 8'd42;
  localparam logic [7:0] CMD_SET_MIN   = 8'd43;
  localparam logic [7:0] CMD_SET_FADE  = 8'd47;
  localparam logic [7:0] CMD_SET_ZONE  = 8'd49;
  localparam logic [7:0] CMD_QRY_GLO   = 8'd50;
  localparam logic [7:0] CMD_QRY_GHI   = 8'd51;
  localparam logic [7:0] CMD_QRY_VER   = 8'd52;
  localparam logic [7:0] CMD_DIRECT    = 8'd201;
  localparam logic [7:0] CMD_MAX       = 8'd208;
  localparam logic [7:0] CMD_OFF       = 8'd212;
  localparam logic [7:0] CMD_DOWN_A    = 8'd216;
  localparam logic [7:0] CMD_DOWN_B    = 8'd241;
  localparam logic [7:0] CMD_UP_A      = 8'd220;
  localparam logic [7:0] CMD_UP_B      = 8'd240;
  localparam logic [7:0] CMD_SCENE_GO  = 8'd231 + 8'd3;
  localparam logic [7:0] CMD_SCENE_PUT = 8'd231;

  // store entries mirrored in registers, then the scene base and the scene count
  localparam logic [7:0] NV_LEVEL  = 8'd0;
  localparam logic [7:0] NV_MIN    = 8'd2;
  localparam logic [7:0] NV_MAX    = 8'd3;
  localparam logic [7:0] NV_FADE   = 8'd4;
  localparam logic [7:0] NV_SHORT  = 8'd6;
  localparam logic [7:0] NV_GRP_LO = 8'd7;
  localparam logic [7:0] NV_GRP_HI = 8'd8;
  localparam logic [7:0] NV_SCENE  = 8'd9;
  localparam logic [7:0] NV_ZONE   = 8'd32;
  localparam logic [7:0] NUM_SCENES = 8'd17;

  localparam logic [9:0] PWM_CAP = 10'd1020;

  // factory image of the store
  function automatic logic [7:0] factory_image(input logic [6:0] idx);
    logic [7:0] v;
    unique case (idx)
      7'd0:  v = 8'd100;
      7'd1:  v = 8'd50;
      7'd2:  v = 8'd0;
      7'd3:  v = 8'd100;
      7'd4:  v = 8'd5;
      7'd5:  v = 8'd6;
      7'd6:  v = 8'd1;
      7'd7:  v = 8'd1;
      7'd8:  v = 8'd0;
      7'd9:  v = 8'd6;
      7'd10: v = 8'd7;
      7'd11: v = 8'd8;
      7'd32: v = 8'd210;
      default: v = 8'hFF;
    endcase
    return v;
  endfunction

  // piecewise level to PWM map, level first limited to the maximum
  function automatic logic [9:0] level_to_power(input logic [7:0] p_in,
                                                input logic [7:0] maxl);
    logic [7:0]  p;
    logic [11:0] v;
    p = (p_in > maxl) ? maxl : p_in;
    if (p < 8'd10)      v = {4'd0, p};
    else if (p < 8'd30) v = 12'd10 + {3'd0, p - 8'd10, 1'b0};
    else if (p < 8'd60) v = 12'd50 + 12'({4'd0, p - 8'd30} * 12'd5);
    else                v = 12'd195 + 12'({4'd0, p - 8'd60} * 12'd10);
    if (v > {2'd0, PWM_CAP}) v = {2'd0, PWM_CAP};
    return v[9:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/dce_ram.sv */
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`default_nettype none
module dce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 33
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/dimmer_command_engine_core.sv */
// Dimmer command engine: frame address match, command execution, fade ramp.
// Flow: a request is taken in S_IDLE and its fields are registered; in S_EXEC the store
// RAM read is used and the result is registered once the result side is free.
// No new request is taken until the previous result has been registered.
// Reset: synchronous; after rst falls the store is loaded with its factory image,
// one entry a cycle until all STORE_DEPTH entries are written, during which no request is taken.
// Depends on dce_pkg and dce_ram.
`default_nettype none
module dimmer_command_engine_core
  import dce_pkg::*;
#(
  parameter int STORE_DEPTH = 33
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // address[7:0], command[15:8], data_byte[23:16], has_data[24]
  input  wire logic        s_tuser,  // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata   // accepted[0], reply_valid[1], reply_address[9:2],
                                     // reply_value[17:10], pwm_level[27:18], lamp_lit[28]
);
  localparam int AW = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {S_FILL, S_IDLE, S_EXEC} state_t;
  state_t state;

  // Reads of entries 0, 2, 3, 4, 6, 7, 8 and 32 come from the registers below;
  // reads of the rest (scenes and spare bytes) come from the RAM.
  logic [7:0]  min_level, max_level, fade_rate, short_address, zone_address;
  logic [15:0] group_mask;
  logic [7:0]  level, dtr, fade_count, last_data;
  logic        lit_flag, dtr_armed;
  logic [9:0]  target_power, current_power;

  logic [AW-1:0] fill_idx;
  logic          kind_q;
  logic [7:0]    addr_q, cmd_q, d_q;
  logic [AW-1:0] rd_addr;

  // request decode
  logic [7:0]    in_addr, in_cmd, in_d;
  logic [8:0]    in_rd_full;
  logic [AW-1:0] in_rd_addr;
  logic          take;

  assign s_tready   = (state == S_IDLE);
  assign take       = s_tvalid && s_tready;
  assign in_addr    = s_tdata[7:0];
  assign in_cmd     = s_tdata[15:8];
  assign in_d       = s_tdata[24] ? s_tdata[23:16] : last_data;
  assign in_rd_full = (in_cmd == CMD_SCENE_GO) ? {1'b0, in_d} + {1'b0, NV_SCENE}
                                               : {1'b0, in_d};
  assign in_rd_addr = in_rd_full[AW-1:0];

  // store RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign ram_raddr = s_tready ? in_rd_addr : rd_addr;

  dce_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // command execution
  logic [7:0]  min_next, max_next, fade_next, short_next, zone_next;
  logic [15:0] group_next;
  logic [7:0]  level_next, dtr_next, fcount_next;
  logic        lit_next, dtr_armed_next, match, rv;
  logic [7:0]  rval, nv_rd;
  logic [9:0]  target_next, current_next;
  logic        ex_we;
  logic [AW-1:0] ex_waddr;
  logic [7:0]  ex_wdata;
  logic [8:0]  scene_full;
  logic        commit;

  assign scene_full = {1'b0, d_q} + {1'b0, NV_SCENE};
  assign commit     = (state == S_EXEC) && (!m_tvalid || m_tready);

  // store read with mirrored entries taken from their registers
  always_comb begin
    unique case (d_q)
      NV_LEVEL:  nv_rd = level;
      NV_MIN:    nv_rd = min_level;
      NV_MAX:    nv_rd = max_level;
      NV_FADE:   nv_rd = fade_rate;
      NV_SHORT:  nv_rd = short_address;
      NV_GRP_LO: nv_rd = group_mask[7:0];
      NV_GRP_HI: nv_rd = group_mask[15:8];
      NV_ZONE:   nv_rd = zone_address;
      default:   nv_rd = ram_rdata;
    endcase
  end

  always_comb begin
    min_next = min_level;   max_next = max_level;     fade_next = fade_rate;
    short_next = short_address; zone_next = zone_address; group_next = group_mask;
    level_next = level;     dtr_next = dtr;           fcount_next = fade_count;
    lit_next = lit_flag;    dtr_armed_next = dtr_armed;
    target_next = target_power; current_next = current_power;
    match = 1'b0; rv = 1'b0; rval = 8'd0;
    ex_we = 1'b0; ex_waddr = d_q[AW-1:0]; ex_wdata = dtr;

    if (kind_q) begin
      // fade tick: count down, step toward target at zero
      if (fade_count != 8'd0) begin
        fcount_next = fade_count - 8'd1;
      end else begin
        fcount_next = fade_rate;
        if (current_power < target_power)      current_next = current_power + 10'd1;
        else if (current_power > target_power) current_next = current_power - 10'd1;
      end
    end else begin
      match = (addr_q == 8'hFF) || (addr_q == short_address) || (addr_q == zone_address)
           || ((addr_q[7:4] == 4'hC) && group_mask[addr_q[3:0]]);
      if (match) begin
        unique case (cmd_q)
          CMD_DIRECT: begin
            if (d_q > max_level)      level_next = max_level;
            else if (d_q < min_level) level_next = min_level;
            else                      level_next = d_q;
            target_next = level_to_power(level_next, max_level);
            lit_next = 1'b1;
          end
          CMD_MAX: begin
            level_next = max_level;
            target_next = level_to_power(max_level, max_level);
            lit_next = 1'b1;
          end
          CMD_OFF: begin
            level_next = 8'd0;
            target_next = level_to_power(min_level, max_level);
            lit_next = 1'b0;
          end
          CMD_DOWN_A, CMD_DOWN_B: begin
            if (lit_flag && level > min_level) begin
              level_next = level - 8'd1;
              target_next = level_to_power(level_next, max_level);
            end
          end
          CMD_UP_A, CMD_UP_B: begin
            if (lit_flag && level < max_level) begin
              level_next = level + 8'd1;
              target_next = level_to_power(level_next, max_level);
            end
          end
          CMD_SCENE_GO: begin
            if (d_q < NUM_SCENES) begin
              if (ram_rdata <= min_level) begin
                level_next = 8'd0;
                target_next = level_to_power(min_level, max_level);
                lit_next = 1'b0;
              end else begin
                level_next = ram_rdata;
                target_next = level_to_power(ram_rdata, max_level);
                lit_next = 1'b1;
              end
            end
          end
          CMD_SCENE_PUT: begin
            if (d_q < NUM_SCENES) begin
              ex_we = 1'b1;
              ex_waddr = scene_full[AW-1:0];
              ex_wdata = level;
            end
          end
          CMD_GRP_EDIT: begin
            group_next[d_q[3:0]] = d_q[4];
          end
          CMD_SET_SHORT: begin
            if (d_q < 8'd64) short_next = d_q;
          end
          CMD_LOAD_DTR: begin
            dtr_next = d_q;
            dtr_armed_next = 1'b1;
          end
          CMD_STORE_DTR: begin
            if (dtr_armed && ({1'b0, d_q} < 9'(STORE_DEPTH))) begin
              dtr_armed_next = 1'b0;
              ex_we = 1'b1;
              // mirrored entries also take the value in their registers, except the level entry
              unique case (d_q)
                NV_MIN:    min_next = dtr;
                NV_MAX:    max_next = dtr;
                NV_FADE:   fade_next = dtr;
                NV_SHORT:  short_next = dtr;
                NV_GRP_LO: group_next[7:0] = dtr;
                NV_GRP_HI: group_next[15:8] = dtr;
                NV_ZONE:   zone_next = dtr;
                default:   ;
              endcase
            end
          end
          CMD_QRY_DTR: begin
            rv = 1'b1; rval = dtr;
          end
          CMD_READ_NV: begin
            if ({1'b0, d_q} < 9'(STORE_DEPTH)) dtr_next = nv_rd;
          end
          CMD_QRY_LEVEL: begin
            rv = 1'b1; rval = level;
          end
          CMD_SET_ZONE: begin
            if (d_q >= 8'd208 && d_q <= 8'd223) zone_next = d_q;
          end
          CMD_QRY_GLO: begin
            rv = 1'b1; rval = group_mask[7:0];
          end
          CMD_QRY_GHI: begin
            rv = 1'b1; rval = group_mask[15:8];
          end
          CMD_SET_MAX:  max_next = d_q;
          CMD_SET_MIN:  min_next = d_q;
          CMD_SET_FADE: fade_next = d_q;
          CMD_QRY_VER: begin
            rv = 1'b1; rval = 8'd1;
          end
          default: ;
        endcase
      end
    end
  end

  // RAM write: factory image during fill, command write-back otherwise
  always_comb begin
    if (state == S_FILL) begin
      ram_we    = 1'b1;
      ram_waddr = fill_idx;
      ram_wdata = factory_image(7'(fill_idx));
    end else begin
      ram_we    = ex_we && commit;
      ram_waddr = ex_waddr;
      ram_wdata = ex_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      fill_idx <= '0;
      m_tvalid <= 1'b0;
      min_level <= 8'd0;     max_level <= 8'd100;    fade_rate <= 8'd5;
      short_address <= 8'd1; zone_address <= 8'd210; group_mask <= 16'd1;
      level <= 8'd100;       lit_flag <= 1'b1;       dtr <= 8'd0;
      dtr_armed <= 1'b0;     target_power <= 10'd595; current_power <= 10'd595;
      fade_count <= 8'd5;    last_data <= 8'd0;
    end else begin
      // raise the result on commit, drop it once taken
      if (commit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_FILL: begin
          fill_idx <= fill_idx + 1'b1;
          if (fill_idx == AW'(STORE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (take) begin
            kind_q  <= s_tuser;
            addr_q  <= in_addr;
            cmd_q   <= in_cmd;
            d_q     <= in_d;
            rd_addr <= in_rd_addr;
            if (!s_tuser) last_data <= in_d;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            min_level <= min_next;  max_level <= max_next;   fade_rate <= fade_next;
            short_address <= short_next; zone_address <= zone_next;
            group_mask <= group_next; level <= level_next;   lit_flag <= lit_next;
            dtr <= dtr_next;        dtr_armed <= dtr_armed_next;
            target_power <= target_next; current_power <= current_next;
            fade_count <= fcount_next;
            m_tdata  <= {3'd0, lit_next, current_next, rval,
                         (rv ? short_next : 8'd0), rv, match};
            state <= S_IDLE;
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

  // the driven PWM value never leaves the mapped range
  assert property (@(posedge clk) disable iff (rst) current_power <= PWM_CAP)
    else $error("pwm value above cap");
  // no request is taken while the store image is loading
  assert property (@(posedge clk) disable iff (rst) (state == S_FILL) |-> !s_tready)
    else $error("request taken during fill");
  // a reply only comes with an accepted frame
  assert property (@(posedge clk) disable iff (rst) (commit && rv) |-> match)
    else $error("reply without address match");
  // a result follows every taken request
  assert property (@(posedge clk) disable iff (rst) commit |=> m_tvalid)
    else $error("result lost");

endmodule
`default_nettype wire
